[hw/rtl/bitr_pkg.sv]
package bitr_pkg;

   localparam int NUM_INPUTS = 4;
   localparam int NUM_SLOTS  = 8;
   localparam int LAST_DEPTH = 8;

   localparam int PORT_W     = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LAST_IDX_W = (LAST_DEPTH > 1) ? $clog2(LAST_DEPTH) : 1;
   localparam int LAST_CNT_W = $clog2(LAST_DEPTH + 1);

   localparam int BYTES_W    = 16;
   localparam int ID_W       = 16;
   localparam int BEAT_W     = 13;
   localparam int QUEUED_W   = BYTES_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [BEAT_W-1:0] BEAT_WIDTH_RESET = BEAT_W'(8);

   typedef enum logic [1:0] {
      FUNC_ADMIT   = 2'd0,
      FUNC_FORWARD = 2'd1,
      FUNC_RESP    = 2'd2,
      FUNC_DROP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DENIED  = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEAT_WIDTH  = 2'd0,
      CSR_MAX_PENDING = 2'd1,
      CSR_SHARED_RW   = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [BEAT_W-1:0]  beat_width_bytes;
      logic [BYTES_W-1:0] max_pending_bytes;
      logic               rw_shared;
   } cfg_type;

   typedef struct packed {
      func_type           func;
      logic [PORT_W-1:0]  input_port;
      logic [SLOT_W-1:0]  slot_index;
      logic               write_beat;
      logic               first_beat;
      logic               is_last;
      logic [BYTES_W-1:0] beat_bytes;
      logic [ID_W-1:0]    master_id;
   } item_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_W-1:0]     slot_out;
      logic                  channel;
      logic [ID_W-1:0]       restored_burst_id;
      logic                  burst_closed;
      logic [NUM_INPUTS-1:0] wake_mask;
   } result_type;

endpackage

[hw/rtl/bitr_slot_alloc.sv]
module bitr_slot_alloc (
   input  logic [bitr_pkg::NUM_SLOTS-1:0] slot_used,
   output logic                           free_found,
   output logic [bitr_pkg::SLOT_W-1:0]    free_slot
);

   // lowest free slot wins
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = bitr_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_used[i]) begin
            free_found = 1'b1;
            free_slot  = bitr_pkg::SLOT_W'(i);
         end
      end
   end

endmodule

[hw/rtl/bitr_core.sv]
module bitr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  bitr_pkg::cfg_type    cfg,
   input  logic                 item_fire,
   input  bitr_pkg::item_type   item,
   output bitr_pkg::result_type result
);

   localparam int NI = bitr_pkg::NUM_INPUTS;
   localparam int NS = bitr_pkg::NUM_SLOTS;

   logic [NS-1:0]                     used_ff, used_in;
   logic [bitr_pkg::LAST_DEPTH-1:0]   fifo_ff [NS];
   logic [bitr_pkg::LAST_DEPTH-1:0]   fifo_in [NS];
   logic [bitr_pkg::LAST_CNT_W-1:0]   cnt_ff [NS];
   logic [bitr_pkg::LAST_CNT_W-1:0]   cnt_in [NS];
   logic [bitr_pkg::QUEUED_W-1:0]     queued_ff [NI];
   logic [bitr_pkg::QUEUED_W-1:0]     queued_in [NI];
   logic [NI-1:0]                     open_valid_ff, open_valid_in;
   logic [bitr_pkg::SLOT_W-1:0]       open_slot_ff [NI];
   logic [bitr_pkg::SLOT_W-1:0]       open_slot_in [NI];
   logic [NI-1:0]                     denied_ff, denied_in;

   // per-slot burst info, written on allocation only
   logic                              slot_chan_ff [NS];
   logic [bitr_pkg::ID_W-1:0]         slot_id_ff [NS];

   logic                              free_found;
   logic [bitr_pkg::SLOT_W-1:0]       free_slot;
   logic                              alloc_we;
   logic                              new_chan;
   logic [bitr_pkg::SLOT_W-1:0]       rd_slot;
   logic                              rd_chan;
   logic [bitr_pkg::ID_W-1:0]         rd_id;
   logic [bitr_pkg::BYTES_W-1:0]      cost;
   logic [bitr_pkg::BYTES_W-1:0]      limit;
   logic [bitr_pkg::QUEUED_W:0]       queued_sum;
   logic [bitr_pkg::QUEUED_W-1:0]     queued_rel;
   logic                              oversize;
   logic                              stray_cont;
   logic                              over_budget;
   logic [bitr_pkg::LAST_CNT_W-1:0]   slot_cnt;
   logic                              master_last;

   bitr_slot_alloc u_alloc (
      .slot_used  (used_ff),
      .free_found (free_found),
      .free_slot  (free_slot)
   );

   // one read port: continuation beats look at the open slot, the rest at the item's slot
   assign rd_slot = (item.func == bitr_pkg::FUNC_ADMIT) ? open_slot_ff[item.input_port]
                                                       : item.slot_index;
   assign rd_chan = slot_chan_ff[rd_slot];
   assign rd_id   = slot_id_ff[rd_slot];

   assign new_chan    = cfg.rw_shared ? 1'b0 : item.write_beat;
   assign cost        = item.write_beat ? item.beat_bytes : '0;
   assign limit       = (cfg.max_pending_bytes != '0) ? cfg.max_pending_bytes
                        : bitr_pkg::BYTES_W'(cfg.beat_width_bytes);
   assign queued_sum  = (bitr_pkg::QUEUED_W + 1)'(queued_ff[item.input_port])
                        + (bitr_pkg::QUEUED_W + 1)'(cost);
   assign queued_rel  = (queued_ff[item.input_port] > bitr_pkg::QUEUED_W'(cost))
                        ? queued_ff[item.input_port] - bitr_pkg::QUEUED_W'(cost) : '0;
   assign oversize    = item.write_beat &&
                        (item.beat_bytes > bitr_pkg::BYTES_W'(cfg.beat_width_bytes));
   assign stray_cont  = !item.first_beat && !open_valid_ff[item.input_port];
   assign over_budget = queued_sum > (bitr_pkg::QUEUED_W + 1)'(limit);
   assign slot_cnt    = cnt_ff[item.slot_index];
   assign master_last = (slot_cnt != '0) && fifo_ff[item.slot_index][0];

   always_comb begin
      used_in       = used_ff;
      fifo_in       = fifo_ff;
      cnt_in        = cnt_ff;
      queued_in     = queued_ff;
      open_valid_in = open_valid_ff;
      open_slot_in  = open_slot_ff;
      denied_in     = denied_ff;
      alloc_we      = 1'b0;
      result        = '0;
      result.status = bitr_pkg::STATUS_INVALID;

      case (item.func)
         bitr_pkg::FUNC_ADMIT: begin
            if (!oversize && !stray_cont) begin
               if (over_budget) begin
                  denied_in[item.input_port] = 1'b1;
                  result.status = bitr_pkg::STATUS_DENIED;
               end else if (item.first_beat) begin
                  if (!free_found) begin
                     denied_in[item.input_port] = 1'b1;
                     result.status = bitr_pkg::STATUS_DENIED;
                  end else begin
                     used_in[free_slot] = 1'b1;
                     alloc_we = 1'b1;
                     if (!item.is_last) begin
                        open_valid_in[item.input_port] = 1'b1;
                        open_slot_in[item.input_port]  = free_slot;
                     end
                     queued_in[item.input_port] = queued_sum[bitr_pkg::QUEUED_W-1:0];
                     result.status   = bitr_pkg::STATUS_OK;
                     result.slot_out = free_slot;
                     result.channel  = new_chan;
                  end
               end else begin
                  // continuation uses the open slot as is, even if freed meanwhile
                  if (item.is_last) open_valid_in[item.input_port] = 1'b0;
                  queued_in[item.input_port] = queued_sum[bitr_pkg::QUEUED_W-1:0];
                  result.status   = bitr_pkg::STATUS_OK;
                  result.slot_out = rd_slot;
                  result.channel  = rd_chan;
               end
            end
         end
         bitr_pkg::FUNC_FORWARD: begin
            if (used_ff[item.slot_index]) begin
               if (slot_cnt < bitr_pkg::LAST_CNT_W'(bitr_pkg::LAST_DEPTH)) begin
                  if (item.is_last)
                     fifo_in[item.slot_index][slot_cnt[bitr_pkg::LAST_IDX_W-1:0]] = 1'b1;
                  cnt_in[item.slot_index] = slot_cnt + bitr_pkg::LAST_CNT_W'(1);
               end
               queued_in[item.input_port] = queued_rel;
               result.wake_mask = denied_ff;
               denied_in        = '0;
               result.status    = bitr_pkg::STATUS_OK;
               result.slot_out  = item.slot_index;
               result.channel   = rd_chan;
            end
         end
         bitr_pkg::FUNC_RESP: begin
            if (used_ff[item.slot_index]) begin
               if ((slot_cnt != '0) && item.is_last) begin
                  fifo_in[item.slot_index] = fifo_ff[item.slot_index] >> 1;
                  cnt_in[item.slot_index]  = slot_cnt - bitr_pkg::LAST_CNT_W'(1);
               end
               result.status            = bitr_pkg::STATUS_OK;
               result.slot_out          = item.slot_index;
               result.channel           = rd_chan;
               result.restored_burst_id = rd_id;
               if (item.is_last && master_last) begin
                  result.burst_closed      = 1'b1;
                  used_in[item.slot_index] = 1'b0;
                  fifo_in[item.slot_index] = '0;
                  cnt_in[item.slot_index]  = '0;
                  result.wake_mask         = denied_ff;
                  denied_in                = '0;
               end
            end
         end
         bitr_pkg::FUNC_DROP: begin
            if (used_ff[item.slot_index]) begin
               queued_in[item.input_port] = queued_rel;
               used_in[item.slot_index]   = 1'b0;
               fifo_in[item.slot_index]   = '0;
               cnt_in[item.slot_index]    = '0;
               if (open_valid_ff[item.input_port] &&
                   open_slot_ff[item.input_port] == item.slot_index)
                  open_valid_in[item.input_port] = 1'b0;
               result.wake_mask = denied_ff;
               denied_in        = '0;
               result.status    = bitr_pkg::STATUS_OK;
               result.slot_out  = item.slot_index;
               result.channel   = rd_chan;
            end
         end
         default: begin
            result.status = bitr_pkg::STATUS_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         open_valid_ff <= '0;
         denied_ff     <= '0;
         for (int s = 0; s < NS; s++) begin
            fifo_ff[s] <= '0;
            cnt_ff[s]  <= '0;
         end
         for (int p = 0; p < NI; p++) queued_ff[p] <= '0;
      end else if (item_fire) begin
         used_ff       <= used_in;
         open_valid_ff <= open_valid_in;
         denied_ff     <= denied_in;
         fifo_ff       <= fifo_in;
         cnt_ff        <= cnt_in;
         queued_ff     <= queued_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) open_slot_ff <= open_slot_in;
   end

   always_ff @(posedge clock) begin
      if (item_fire && alloc_we) begin
         slot_chan_ff[free_slot] <= new_chan;
         slot_id_ff[free_slot]   <= item.master_id;
      end
   end

endmodule

[hw/rtl/burst_id_remap_tracker_top.sv]
// channel | direction | handshake       | payload
// req     | in        | req_valid/ready | func, port, slot, beat flags, bytes, master id
// rsp     | out       | rsp_valid/ready | status, slot, channel, master id, closed, wake
// csr     | in        | csr_valid/ready | csr_index, csr_wdata
//
// One item per cycle sustained while rsp is not stalled; an item's result is registered:
// the input register takes the item, then the table update goes into the result register.
// The slot table is updated in the same cycle as the result register is loaded,
// so the next item already sees it.
// Synchronous active-high reset clears the table; no clearing pass is needed.
// A stalled rsp holds the pipeline; req_ready drops only when both stages are full.
module burst_id_remap_tracker_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [bitr_pkg::PORT_W-1:0]         req_input_port,
   input  logic [bitr_pkg::SLOT_W-1:0]         req_slot_index,
   input  logic                                req_write_beat,
   input  logic                                req_first_beat,
   input  logic                                req_last_beat,
   input  logic [bitr_pkg::BYTES_W-1:0]        req_beat_bytes,
   input  logic [bitr_pkg::ID_W-1:0]           req_master_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [bitr_pkg::SLOT_W-1:0]         rsp_slot_out,
   output logic                                rsp_channel,
   output logic [bitr_pkg::ID_W-1:0]           rsp_restored_burst_id,
   output logic                                rsp_burst_closed,
   output logic [bitr_pkg::NUM_INPUTS-1:0]     rsp_wake_mask,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bitr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bitr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bitr_pkg::cfg_type    cfg_ff;
   bitr_pkg::item_type   item_ff, item_in;
   bitr_pkg::result_type result_ff, result_in;
   logic                 stage_valid_ff, stage_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beat_width_bytes  <= bitr_pkg::BEAT_WIDTH_RESET;
         cfg_ff.max_pending_bytes <= '0;
         cfg_ff.rw_shared         <= 1'b0;
      end else if (csr_valid) begin
         case (bitr_pkg::csr_idx_type'(csr_index))
            bitr_pkg::CSR_BEAT_WIDTH:
               cfg_ff.beat_width_bytes <= csr_wdata[bitr_pkg::BEAT_W-1:0];
            bitr_pkg::CSR_MAX_PENDING:
               cfg_ff.max_pending_bytes <= csr_wdata;
            bitr_pkg::CSR_SHARED_RW:
               cfg_ff.rw_shared <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = stage_valid_ff && advance;
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      item_in.func       = bitr_pkg::func_type'(req_func);
      item_in.input_port = req_input_port;
      item_in.slot_index = req_slot_index;
      item_in.write_beat = req_write_beat;
      item_in.first_beat = req_first_beat;
      item_in.is_last    = req_last_beat;
      item_in.beat_bytes = req_beat_bytes;
      item_in.master_id  = req_master_id;
   end

   assign stage_valid_in = (req_valid && req_ready) || (stage_valid_ff && !advance);
   assign rsp_valid_in   = fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) item_ff <= item_in;
      if (fire) result_ff <= result_in;
   end

   bitr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_fire (fire),
      .item      (item_ff),
      .result    (result_in)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = result_ff.status;
   assign rsp_slot_out          = result_ff.slot_out;
   assign rsp_channel           = result_ff.channel;
   assign rsp_restored_burst_id = result_ff.restored_burst_id;
   assign rsp_burst_closed      = result_ff.burst_closed;
   assign rsp_wake_mask         = result_ff.wake_mask;

endmodule

[hw/rtl/bitr_checker.sv]
module bitr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_status,
   input logic [bitr_pkg::SLOT_W-1:0]     rsp_slot_out,
   input logic                            rsp_channel,
   input logic [bitr_pkg::ID_W-1:0]       rsp_restored_burst_id,
   input logic                            rsp_burst_closed,
   input logic [bitr_pkg::NUM_INPUTS-1:0] rsp_wake_mask
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_out) && $stable(rsp_restored_burst_id) && $stable(rsp_wake_mask))
      else $error("rsp item changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == bitr_pkg::STATUS_OK ||
                    rsp_status == bitr_pkg::STATUS_DENIED ||
                    rsp_status == bitr_pkg::STATUS_INVALID)
      else $error("undefined status code");

   // refused items carry no slot, channel, id or side effects
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bitr_pkg::STATUS_OK |->
      rsp_slot_out == '0 && !rsp_channel && rsp_restored_burst_id == '0 &&
      !rsp_burst_closed && rsp_wake_mask == '0)
      else $error("refused item carries payload");

   // a completed burst always comes with status ok on a response
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_burst_closed |-> rsp_status == bitr_pkg::STATUS_OK)
      else $error("burst done without ok status");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item visible after reset");

endmodule

bind burst_id_remap_tracker_top bitr_checker u_bitr_checker (.*);

[bench/tb_burst_id_remap_tracker_top.sv]
`timescale 1ns / 1ps

module tb_burst_id_remap_tracker_top;

   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int HOLD_CYCLES     = 60;
   localparam int TIMEOUT_NS      = 4_000_000;
   localparam int NI              = bitr_pkg::NUM_INPUTS;
   localparam int NS              = bitr_pkg::NUM_SLOTS;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [1:0]                        req_func = '0;
   logic [bitr_pkg::PORT_W-1:0]       req_input_port = '0;
   logic [bitr_pkg::SLOT_W-1:0]       req_slot_index = '0;
   logic                              req_write_beat = 1'b0;
   logic                              req_first_beat = 1'b0;
   logic                              req_last_beat = 1'b0;
   logic [bitr_pkg::BYTES_W-1:0]      req_beat_bytes = '0;
   logic [bitr_pkg::ID_W-1:0]         req_master_id = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [1:0]                        rsp_status;
   logic [bitr_pkg::SLOT_W-1:0]       rsp_slot_out;
   logic                              rsp_channel;
   logic [bitr_pkg::ID_W-1:0]         rsp_restored_burst_id;
   logic                              rsp_burst_closed;
   logic [NI-1:0]                     rsp_wake_mask;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [bitr_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [bitr_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   burst_id_remap_tracker_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_input_port        (req_input_port),
      .req_slot_index        (req_slot_index),
      .req_write_beat        (req_write_beat),
      .req_first_beat        (req_first_beat),
      .req_last_beat         (req_last_beat),
      .req_beat_bytes        (req_beat_bytes),
      .req_master_id         (req_master_id),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot_out          (rsp_slot_out),
      .rsp_channel           (rsp_channel),
      .rsp_restored_burst_id (rsp_restored_burst_id),
      .rsp_burst_closed      (rsp_burst_closed),
      .rsp_wake_mask         (rsp_wake_mask),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // shadow of the burst table
   bitr_pkg::cfg_type tracker_cfg = '{beat_width_bytes: bitr_pkg::BEAT_WIDTH_RESET,
                                      max_pending_bytes: '0, rw_shared: 1'b0};
   logic                            slot_used [NS] = '{default: 1'b0};
   logic [bitr_pkg::PORT_W-1:0]     slot_owner [NS] = '{default: '0};
   logic                            slot_chan [NS] = '{default: 1'b0};
   logic [bitr_pkg::ID_W-1:0]       slot_master_id [NS] = '{default: '0};
   logic [bitr_pkg::LAST_DEPTH-1:0] last_fifo [NS] = '{default: '0};
   int                              last_count [NS] = '{default: 0};
   int                              queued_bytes [NI] = '{default: 0};
   logic                            open_valid [NI] = '{default: 1'b0};
   int                              open_slot [NI] = '{default: 0};
   logic                            denied [NI] = '{default: 1'b0};

   bitr_pkg::item_type   outbound_items [$];
   bitr_pkg::result_type awaited_results [$];

   int  items_pushed = 0;
   int  items_accepted = 0;
   bit  req_accepted = 1'b0;
   int  idle_pct = 21;
   int  holds_requested = 0;
   int  holds_served = 0;
   int  hold_left = 0;
   int  mismatches = 0;
   int  n_ok = 0, n_denied = 0, n_invalid = 0, n_closed = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out at %0t ns with %0d results outstanding", $time,
               awaited_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [NI-1:0] wake_denied();
      logic [NI-1:0] m;
      m = '0;
      for (int i = 0; i < NI; i++) begin
         if (denied[i]) begin
            denied[i] = 1'b0;
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic void release_bytes(input int p, input logic wr, input int bytes);
      int c;
      c = wr ? bytes : 0;
      queued_bytes[p] = (queued_bytes[p] > c) ? queued_bytes[p] - c : 0;
   endfunction

   function automatic void free_slot(input int s);
      slot_used[s] = 1'b0;
      last_fifo[s] = '0;
      last_count[s] = 0;
   endfunction

   function automatic bitr_pkg::result_type track_item(input bitr_pkg::item_type it);
      bitr_pkg::result_type r;
      int p, s, cost, limit;
      logic head;
      r = '0;
      r.status = bitr_pkg::STATUS_INVALID;
      p = int'(it.input_port);
      s = int'(it.slot_index);
      head = 1'b0;
      case (it.func)
         bitr_pkg::FUNC_ADMIT: begin
            if (!(it.write_beat &&
                  it.beat_bytes > bitr_pkg::BYTES_W'(tracker_cfg.beat_width_bytes)) &&
                (it.first_beat || open_valid[p])) begin
               cost = it.write_beat ? int'(it.beat_bytes) : 0;
               limit = (tracker_cfg.max_pending_bytes != 0) ?
                       int'(tracker_cfg.max_pending_bytes) :
                       int'(tracker_cfg.beat_width_bytes);
               if (queued_bytes[p] + cost > limit) begin
                  denied[p] = 1'b1;
                  r.status = bitr_pkg::STATUS_DENIED;
               end else if (!it.first_beat) begin
                  // continuation: slot taken as is, even if freed meanwhile
                  s = open_slot[p];
                  if (it.is_last) open_valid[p] = 1'b0;
                  queued_bytes[p] += cost;
                  r.status = bitr_pkg::STATUS_OK;
                  r.slot_out = bitr_pkg::SLOT_W'(s);
                  r.channel = slot_chan[s];
               end else begin
                  s = NS;
                  for (int i = NS - 1; i >= 0; i--) if (!slot_used[i]) s = i;
                  if (s == NS) begin
                     denied[p] = 1'b1;
                     r.status = bitr_pkg::STATUS_DENIED;
                  end else begin
                     slot_used[s] = 1'b1;
                     slot_owner[s] = it.input_port;
                     slot_chan[s] = tracker_cfg.rw_shared ? 1'b0 : it.write_beat;
                     slot_master_id[s] = it.master_id;
                     if (!it.is_last) begin
                        open_valid[p] = 1'b1;
                        open_slot[p] = s;
                     end
                     queued_bytes[p] += cost;
                     r.status = bitr_pkg::STATUS_OK;
                     r.slot_out = bitr_pkg::SLOT_W'(s);
                     r.channel = slot_chan[s];
                  end
               end
            end
         end
         bitr_pkg::FUNC_FORWARD: begin
            if (slot_used[s]) begin
               // flag dropped silently once the FIFO is full
               if (last_count[s] < bitr_pkg::LAST_DEPTH) begin
                  if (it.is_last) last_fifo[s][last_count[s]] = 1'b1;
                  last_count[s]++;
               end
               release_bytes(p, it.write_beat, int'(it.beat_bytes));
               r.wake_mask = wake_denied();
               r.status = bitr_pkg::STATUS_OK;
               r.slot_out = bitr_pkg::SLOT_W'(s);
               r.channel = slot_chan[s];
            end
         end
         bitr_pkg::FUNC_RESP: begin
            if (slot_used[s]) begin
               if (last_count[s] > 0) begin
                  head = last_fifo[s][0];
                  if (it.is_last) begin
                     last_fifo[s] = last_fifo[s] >> 1;
                     last_count[s]--;
                  end
               end
               r.status = bitr_pkg::STATUS_OK;
               r.slot_out = bitr_pkg::SLOT_W'(s);
               r.channel = slot_chan[s];
               r.restored_burst_id = slot_master_id[s];
               if (it.is_last && head) begin
                  r.burst_closed = 1'b1;
                  free_slot(s);
                  r.wake_mask = wake_denied();
               end
            end
         end
         default: begin
            if (slot_used[s]) begin
               r.channel = slot_chan[s];
               release_bytes(p, it.write_beat, int'(it.beat_bytes));
               free_slot(s);
               if (open_valid[p] && open_slot[p] == s) open_valid[p] = 1'b0;
               r.wake_mask = wake_denied();
               r.status = bitr_pkg::STATUS_OK;
               r.slot_out = bitr_pkg::SLOT_W'(s);
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field,
                  want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      bitr_pkg::result_type want;
      bitr_pkg::item_type   seen;
      req_accepted = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: result with nothing expected, expected none actual %0h",
                        $time, {rsp_status, rsp_slot_out, rsp_channel});
            end else begin
               want = awaited_results[0];
               awaited_results.delete(0);
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("slot_out", 16'(want.slot_out), 16'(rsp_slot_out));
               check_field("channel", 16'(want.channel), 16'(rsp_channel));
               check_field("restored_burst_id", want.restored_burst_id,
                           rsp_restored_burst_id);
               check_field("burst_closed", 16'(want.burst_closed), 16'(rsp_burst_closed));
               check_field("wake_mask", 16'(want.wake_mask), 16'(rsp_wake_mask));
               case (want.status)
                  bitr_pkg::STATUS_OK:     n_ok++;
                  bitr_pkg::STATUS_DENIED: n_denied++;
                  default:                 n_invalid++;
               endcase
               if (want.burst_closed) n_closed++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (bitr_pkg::csr_idx_type'(csr_index))
               bitr_pkg::CSR_BEAT_WIDTH:
                  tracker_cfg.beat_width_bytes = csr_wdata[bitr_pkg::BEAT_W-1:0];
               bitr_pkg::CSR_MAX_PENDING:
                  tracker_cfg.max_pending_bytes = csr_wdata;
               bitr_pkg::CSR_SHARED_RW:
                  tracker_cfg.rw_shared = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            seen.func = bitr_pkg::func_type'(req_func);
            seen.input_port = req_input_port;
            seen.slot_index = req_slot_index;
            seen.write_beat = req_write_beat;
            seen.first_beat = req_first_beat;
            seen.is_last = req_last_beat;
            seen.beat_bytes = req_beat_bytes;
            seen.master_id = req_master_id;
            awaited_results.insert(awaited_results.size(), track_item(seen));
            items_accepted++;
            req_accepted = 1'b1;
         end
      end
   end

   always @(negedge clock) begin : sender
      bitr_pkg::item_type nxt;
      if (!req_valid || req_accepted) begin
         if (outbound_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
            nxt = outbound_items[0];
            outbound_items.delete(0);
            req_func <= nxt.func;
            req_input_port <= nxt.input_port;
            req_slot_index <= nxt.slot_index;
            req_write_beat <= nxt.write_beat;
            req_first_beat <= nxt.first_beat;
            req_last_beat <= nxt.is_last;
            req_beat_bytes <= nxt.beat_bytes;
            req_master_id <= nxt.master_id;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (holds_served < holds_requested) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   function automatic bitr_pkg::item_type beat(input bitr_pkg::func_type f, input int port,
                                               input int slot, input bit wr, input bit first,
                                               input bit last, input int bytes,
                                               input int id);
      bitr_pkg::item_type it;
      it.func = f;
      it.input_port = bitr_pkg::PORT_W'(port);
      it.slot_index = bitr_pkg::SLOT_W'(slot);
      it.write_beat = wr;
      it.first_beat = first;
      it.is_last = last;
      it.beat_bytes = bitr_pkg::BYTES_W'(bytes);
      it.master_id = bitr_pkg::ID_W'(id);
      return it;
   endfunction

   function automatic int busy_slot();
      int busy [$];
      for (int i = 0; i < NS; i++) if (slot_used[i]) busy.insert(busy.size(), i);
      return (busy.size() != 0) ? busy[$urandom_range(busy.size() - 1)] :
                                  int'($urandom_range(NS - 1));
   endfunction

   // mostly plausible traffic steered by the shadow table, some pure noise
   function automatic bitr_pkg::item_type make_item();
      int pick, bw, s, port;
      bit wr, first;
      pick = int'($urandom_range(99));
      bw = int'(tracker_cfg.beat_width_bytes);
      wr = bit'($urandom_range(1));
      port = int'($urandom_range(NI - 1));
      if (pick < 42) begin
         first = !(open_valid[port] && $urandom_range(99) < 65);
         return beat(bitr_pkg::FUNC_ADMIT, port, int'($urandom_range(NS - 1)), wr, first,
                     $urandom_range(99) < (first ? 35 : 40),
                     (wr && $urandom_range(99) < 85) ? int'($urandom_range(bw)) :
                                                      int'($urandom_range(16'hFFFF)),
                     int'($urandom_range(16'hFFFF)));
      end
      s = busy_slot();
      if ($urandom_range(99) < 85) port = int'(slot_owner[s]);
      if (pick < 66)
         return beat(bitr_pkg::FUNC_FORWARD, port, s, wr, bit'($urandom_range(1)),
                     bit'($urandom_range(1)), int'($urandom_range(bw)),
                     int'($urandom_range(16'hFFFF)));
      if (pick < 90)
         return beat(bitr_pkg::FUNC_RESP, port, s, wr, bit'($urandom_range(1)),
                     $urandom_range(99) < 60, int'($urandom_range(16'hFFFF)),
                     int'($urandom_range(16'hFFFF)));
      if (pick < 95)
         return beat(bitr_pkg::FUNC_DROP, port, s, wr, bit'($urandom_range(1)),
                     bit'($urandom_range(1)), int'($urandom_range(bw)),
                     int'($urandom_range(16'hFFFF)));
      return beat(bitr_pkg::func_type'(2'($urandom_range(3))), port,
                  int'($urandom_range(NS - 1)), wr, bit'($urandom_range(1)),
                  bit'($urandom_range(1)), int'($urandom_range(16'hFFFF)),
                  int'($urandom_range(16'hFFFF)));
   endfunction

   task automatic send(input bitr_pkg::item_type it);
      outbound_items.insert(outbound_items.size(), it);
      items_pushed++;
   endtask

   task automatic wait_idle();
      while (items_accepted != items_pushed || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input bitr_pkg::csr_idx_type idx,
                            input logic [bitr_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int ph, n, bw, mp, s, k;
      bit sh;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass on reset settings: width 8, budget follows width
      send(beat(bitr_pkg::FUNC_ADMIT, 3, 0, 0, 0, 0, 0, 0));              // stray continuation
      send(beat(bitr_pkg::FUNC_ADMIT, 3, 0, 1, 1, 1, 16'hFFFF, 16'h1234)); // oversize write
      send(beat(bitr_pkg::FUNC_ADMIT, 0, 0, 0, 1, 0, 16'hFFFF, 16'hFFFF)); // read burst opens
      send(beat(bitr_pkg::FUNC_ADMIT, 1, 0, 1, 1, 1, 8, 0));
      send(beat(bitr_pkg::FUNC_ADMIT, 1, 0, 1, 1, 1, 1, 16'h00AA));      // over budget
      send(beat(bitr_pkg::FUNC_FORWARD, 1, 1, 1, 0, 1, 8, 0));
      send(beat(bitr_pkg::FUNC_RESP, 0, 1, 0, 0, 0, 0, 0));                // peek only
      send(beat(bitr_pkg::FUNC_RESP, 0, 1, 0, 0, 1, 0, 0));                // closes burst
      send(beat(bitr_pkg::FUNC_RESP, 0, 1, 0, 0, 1, 0, 0));                // slot not in use
      send(beat(bitr_pkg::FUNC_RESP, 0, 0, 0, 0, 1, 0, 0));                // empty last FIFO
      send(beat(bitr_pkg::FUNC_FORWARD, 0, 0, 0, 0, 1, 0, 0));
      send(beat(bitr_pkg::FUNC_RESP, 0, 0, 0, 0, 1, 0, 0));
      send(beat(bitr_pkg::FUNC_ADMIT, 0, 5, 0, 0, 0, 100, 0));             // into freed slot
      for (k = 0; k < NS; k++)
         send(beat(bitr_pkg::FUNC_ADMIT, 2, 0, 0, 1, 1, 0, 16'h8000 + k));
      send(beat(bitr_pkg::FUNC_ADMIT, 3, 0, 0, 1, 1, 0, 16'h7FFF));        // table full
      send(beat(bitr_pkg::FUNC_DROP, 3, 7, 1, 0, 0, 16'hFFFF, 0));         // release saturates
      send(beat(bitr_pkg::FUNC_ADMIT, 0, 0, 1, 0, 1, 8, 0));
      send(beat(bitr_pkg::FUNC_DROP, 2, 0, 0, 0, 0, 0, 0));

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         case (ph)
            0: begin bw = 8;    mp = 0;     sh = 1'b0; end
            1: begin bw = 4096; mp = 65535; sh = 1'b1; end
            2: begin bw = 1;    mp = 0;     sh = 1'b0; end
            3: begin bw = 64;   mp = 200;   sh = 1'b0; end
            4: begin bw = 4096; mp = 0;     sh = 1'b1; end
            5: begin
               bw = int'($urandom_range(1, 4096));
               mp = int'($urandom_range(16'hFFFF));
               sh = bit'($urandom_range(1));
            end
            6: begin bw = 16;   mp = 1;     sh = 1'b0; end
            default: begin bw = 300; mp = 0; sh = 1'b1; end
         endcase
         write_csr(bitr_pkg::CSR_BEAT_WIDTH, bitr_pkg::CSR_DATA_W'(bw));
         write_csr(bitr_pkg::CSR_MAX_PENDING, bitr_pkg::CSR_DATA_W'(mp));
         write_csr(bitr_pkg::CSR_SHARED_RW, bitr_pkg::CSR_DATA_W'(sh));
         idle_pct = (ph == 3) ? 0 : 21;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            while (items_pushed - items_accepted >= 3) @(negedge clock);
            if ((ph == 1 || ph == 5) && n == 40) holds_requested++;
            if ($urandom_range(99) < 2) begin
               // run of forwards to overfill one slot's last FIFO
               s = busy_slot();
               for (k = 0; k < bitr_pkg::LAST_DEPTH + 2; k++)
                  send(beat(bitr_pkg::FUNC_FORWARD, int'(slot_owner[s]), s, 0, 0,
                            bit'($urandom_range(1)), 0, 0));
            end else begin
               send(make_item());
            end
         end
      end
      wait_idle();
      repeat (8) @(negedge clock);

      $display("Ran %0d items over %0d register settings, with response hold-offs",
               items_accepted, NUM_PHASES + 1);
      $display("Outcomes: %0d ok, %0d denied, %0d invalid, %0d bursts closed",
               n_ok, n_denied, n_invalid, n_closed);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/bitr_pkg.sv
hw/rtl/bitr_slot_alloc.sv
hw/rtl/bitr_core.sv
hw/rtl/burst_id_remap_tracker_top.sv
hw/rtl/bitr_checker.sv
bench/tb_burst_id_remap_tracker_top.sv
